// ----- rtl/asms_pkg.sv -----
package asms_pkg;

    // working word: 40-bit two's complement, saturating at +-(2^39 - 1)
    localparam int W = 40;
    localparam int MW = 39;
    localparam int FRAC_DEF = 16;
    localparam logic [MW-1:0] SATL_MAG = '1;
    localparam logic signed [W-1:0] SATL = {1'b0, SATL_MAG};

    typedef logic signed [W-1:0] word_t;
    typedef logic [MW-1:0] mag_t;

    function automatic longint clampw_c(longint a);
        longint lim;
        lim = (longint'(1) <<< MW) - 1;
        if (a > lim)
            return lim;
        if (a < -lim)
            return -lim;
        return a;
    endfunction

    // constant in millionths, rounded to the fixed-point grid
    function automatic longint qc(longint micro, int frac);
        return ((micro <<< frac) + 500000) / 1000000;
    endfunction

    function automatic mag_t mag(word_t x);
        word_t n;
        n = -x;
        return x[W-1] ? n[MW-1:0] : x[MW-1:0];
    endfunction

    function automatic word_t sat_sum(logic signed [W:0] x);
        logic signed [W:0] hi;
        logic signed [W:0] lo;
        hi = {2'b00, SATL_MAG};
        lo = -hi;
        if (x > hi)
            return SATL;
        if (x < lo)
            return -SATL;
        return x[W-1:0];
    endfunction

    function automatic word_t clamp32(word_t x);
        if (x > word_t'(64'sd2147483647))
            return word_t'(64'sd2147483647);
        if (x < word_t'(-64'sd2147483648))
            return word_t'(-64'sd2147483648);
        return x;
    endfunction

endpackage

// ----- rtl/asms_mul.sv -----
module asms_mul #(
    parameter int FRAC_BITS = asms_pkg::FRAC_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  asms_pkg::word_t     a,
    input  asms_pkg::word_t     b,
    output logic                done,
    output asms_pkg::word_t     y
);
    import asms_pkg::*;

    localparam int PW = 2 * MW;
    localparam int CW = $clog2(MW + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [PW-1:0] prod_reg;
    logic [PW-1:0] prod_next;
    mag_t          mcand_reg;
    logic          neg_reg;
    logic          done_reg;
    word_t         y_reg;
    logic [MW:0]   upper;
    logic [PW:0]   rnd;
    logic [PW:0]   sh;
    mag_t          rmag;
    word_t         rword;

    // one multiplier bit per cycle, partial sum shifts right
    always_comb
    begin
        upper = {1'b0, prod_reg[PW-1:MW]} + (prod_reg[0] ? {1'b0, mcand_reg} : '0);
        prod_next = {upper, prod_reg[MW-1:1]};
        rnd = {1'b0, prod_reg} + ((PW+1)'(1) << (FRAC_BITS - 1));
        sh = rnd >> FRAC_BITS;
        rmag = (sh > {{(PW+1-MW){1'b0}}, SATL_MAG}) ? SATL_MAG : sh[MW-1:0];
        rword = {1'b0, rmag};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= CW'(MW);
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
                cnt_reg <= cnt_reg - 1'b1;
            else
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
            done_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            prod_reg <= {{MW{1'b0}}, mag(a)};
            mcand_reg <= mag(b);
            neg_reg <= a[W-1] ^ b[W-1];
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
                prod_reg <= prod_next;
            else
                y_reg <= neg_reg ? -rword : rword;
        end
    end

    assign done = done_reg;
    assign y = y_reg;

endmodule

// ----- rtl/asms_div.sv -----
module asms_div #(
    parameter int FRAC_BITS = asms_pkg::FRAC_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  asms_pkg::word_t     a,
    input  asms_pkg::word_t     b,
    output logic                done,
    output asms_pkg::word_t     y
);
    import asms_pkg::*;

    localparam int NW = MW + FRAC_BITS + 1;
    localparam int CW = $clog2(NW + 1);

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] num_reg;
    logic [NW-1:0] num_next;
    mag_t          rem_reg;
    mag_t          rem_next;
    mag_t          dvs_reg;
    logic          neg_reg;
    logic          done_reg;
    word_t         y_reg;
    mag_t          ub;
    logic [NW-1:0] num0;
    logic [MW:0]   rem_sh;
    logic [MW:0]   diff;
    mag_t          rmag;
    word_t         rword;

    always_comb
    begin
        ub = (b[W-1] || b == '0) ? MW'(1) : b[MW-1:0];
        // numerator carries the half-divisor so the quotient rounds to nearest
        num0 = ({{(FRAC_BITS+1){1'b0}}, mag(a)} << FRAC_BITS) + NW'(ub >> 1);
        rem_sh = {rem_reg, num_reg[NW-1]};
        diff = rem_sh - {1'b0, dvs_reg};
        if (!diff[MW])
        begin
            rem_next = diff[MW-1:0];
            num_next = {num_reg[NW-2:0], 1'b1};
        end
        else
        begin
            rem_next = rem_sh[MW-1:0];
            num_next = {num_reg[NW-2:0], 1'b0};
        end
        rmag = (num_reg > NW'(SATL_MAG)) ? SATL_MAG : num_reg[MW-1:0];
        rword = {1'b0, rmag};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg <= CW'(NW);
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
                cnt_reg <= cnt_reg - 1'b1;
            else
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
            done_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= num0;
            rem_reg <= '0;
            dvs_reg <= ub;
            neg_reg <= a[W-1];
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                num_reg <= num_next;
                rem_reg <= rem_next;
            end
            else
                y_reg <= neg_reg ? -rword : rword;
        end
    end

    assign done = done_reg;
    assign y = y_reg;

endmodule

// ----- rtl/adaptive_sliding_mode_steering.sv -----
// Sliding-mode lateral steering controller. One input word carries a full control
// sample; one output word carries the steering command. Speed-dependent vehicle
// coefficients, the sliding surface, the boundary-layer term and the division by
// the steering gain are evaluated by a short step sequencer that drives one
// bit-serial multiplier (one multiplier bit per cycle) and one bit-serial
// restoring divider (one quotient bit per cycle). The sequence has ten products,
// six quotients and fifteen add or subtract steps per sample. A new sample is
// taken once the previous one has fully updated the integral state; the finished
// command waits in its own output register, and the final division is held back
// while an earlier command still waits there.
module adaptive_sliding_mode_steering #(
    parameter int FRAC_BITS = asms_pkg::FRAC_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // lateral_velocity, yaw_rate, lateral_error, error_rate, reach_gain,
    // surface_slope, speed, zero pad
    input  logic [215:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // steer_command
    output logic [31:0]  m_tdata
);
    import asms_pkg::*;

    localparam longint ONE = longint'(1) <<< FRAC_BITS;
    localparam word_t K1 = word_t'(clampw_c(qc(201435135, FRAC_BITS)));
    localparam word_t K2 = word_t'(clampw_c(qc(15986619, FRAC_BITS)));
    localparam word_t K3 = word_t'(clampw_c(qc(24797910, FRAC_BITS)));
    localparam word_t K4 = word_t'(clampw_c(qc(61879178, FRAC_BITS)));
    localparam word_t K5 = word_t'(clampw_c(qc(12469564, FRAC_BITS)));
    localparam word_t K6 = word_t'(clampw_c(qc(111323423, FRAC_BITS)));
    localparam word_t K7 = word_t'(clampw_c(qc(74638252, FRAC_BITS)));
    localparam word_t DD = word_t'(clampw_c(qc(1000, FRAC_BITS)));
    localparam word_t C_ONE = word_t'(clampw_c(ONE));
    localparam word_t C_V40 = word_t'(clampw_c(40 * ONE));
    localparam word_t C_2 = word_t'(clampw_c(2 * ONE));
    localparam word_t C_11 = word_t'(clampw_c(11 * ONE));
    localparam word_t C_1000 = word_t'(clampw_c(1000 * ONE));
    localparam word_t C_2000 = word_t'(clampw_c(2000 * ONE));
    localparam word_t C_50000 = word_t'(clampw_c(50000 * ONE));

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [3:0] D_P0 = 4'd0;
    localparam logic [3:0] D_P1 = 4'd1;
    localparam logic [3:0] D_P2 = 4'd2;
    localparam logic [3:0] D_C41 = 4'd3;
    localparam logic [3:0] D_C42 = 4'd4;
    localparam logic [3:0] D_C44 = 4'd5;
    localparam logic [3:0] D_C45 = 4'd6;
    localparam logic [3:0] D_H = 4'd7;
    localparam logic [3:0] D_S = 4'd8;
    localparam logic [3:0] D_BL = 4'd9;
    localparam logic [3:0] D_TQ = 4'd10;
    localparam logic [3:0] D_TOT = 4'd11;
    localparam logic [3:0] D_OUT = 4'd12;
    localparam logic [3:0] D_INT = 4'd13;

    localparam logic [4:0] LAST_STEP = 5'd30;
    localparam logic [4:0] OUT_STEP = 5'd26;

    logic [1:0] state_reg;
    logic [4:0] pc_reg;
    word_t vy_reg, r_reg, e1_reg, de1_reg, q_reg, c_reg, v_reg;
    word_t p0_reg, p1_reg, p2_reg, c41_reg, c42_reg, c44_reg, c45_reg;
    word_t h_reg, s_reg, bl_reg, tq_reg, tot_reg, integ_reg;
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;

    logic [1:0] op;
    logic [3:0] dst;
    word_t      opa, opb, res, alu_res, as_val, v_in;
    logic       unit_start, mul_done, div_done, wr_en;
    word_t      mul_y, div_y;
    logic       big_s;

    always_comb
    begin
        as_val = {1'b0, mag(s_reg)};
        big_s = as_val > DD;
        op = OP_ADD;
        dst = D_P0;
        opa = '0;
        opb = '0;
        case (pc_reg)
            5'd0:  begin op = OP_MUL; dst = D_P0;  opa = K2;      opb = v_reg;   end
            5'd1:  begin op = OP_MUL; dst = D_P1;  opa = K5;      opb = v_reg;   end
            5'd2:  begin op = OP_MUL; dst = D_P2;  opa = K7;      opb = v_reg;   end
            5'd3:  begin op = OP_DIV; dst = D_C42; opa = K3;      opb = v_reg;   end
            5'd4:  begin op = OP_DIV; dst = D_C44; opa = K1;      opb = v_reg;   end
            5'd5:  begin op = OP_SUB; dst = D_C41; opa = K1;      opb = p0_reg;  end
            5'd6:  begin op = OP_SUB; dst = D_C42; opa = c42_reg; opb = K4;      end
            5'd7:  begin op = OP_SUB; dst = D_C42; opa = c42_reg; opb = p1_reg;  end
            5'd8:  begin op = OP_SUB; dst = D_C44; opa = K2;      opb = c44_reg; end
            5'd9:  begin op = OP_ADD; dst = D_C45; opa = K6;      opb = p2_reg;  end
            5'd10: begin op = OP_MUL; dst = D_P0;  opa = c41_reg; opb = vy_reg;  end
            5'd11: begin op = OP_MUL; dst = D_P1;  opa = c42_reg; opb = r_reg;   end
            5'd12: begin op = OP_ADD; dst = D_H;   opa = p0_reg;  opb = p1_reg;  end
            5'd13: begin op = OP_MUL; dst = D_P0;  opa = c_reg;   opb = e1_reg;  end
            5'd14: begin op = OP_ADD; dst = D_S;   opa = p0_reg;  opb = de1_reg; end
            5'd15: begin op = OP_MUL; dst = D_P0;  opa = s_reg;   opb = as_val;  end
            5'd16:
            begin
                // outside the boundary layer the smoothing term is linear in s
                op = OP_DIV;
                dst = D_BL;
                opa = big_s ? s_reg : p0_reg;
                opb = big_s ? C_2000 : C_2;
            end
            5'd17: begin op = OP_MUL; dst = D_P0;  opa = q_reg;   opb = s_reg;   end
            5'd18: begin op = OP_DIV; dst = D_TQ;  opa = p0_reg;  opb = C_1000;  end
            5'd19: begin op = OP_ADD; dst = D_P1;  opa = c_reg;   opb = c44_reg; end
            5'd20: begin op = OP_MUL; dst = D_P0;  opa = p1_reg;  opb = de1_reg; end
            5'd21: begin op = OP_SUB; dst = D_TOT; opa = '0;      opb = h_reg;   end
            5'd22: begin op = OP_SUB; dst = D_TOT; opa = tot_reg; opb = p0_reg;  end
            5'd23: begin op = OP_SUB; dst = D_TOT; opa = tot_reg; opb = tq_reg;  end
            5'd24: begin op = OP_SUB; dst = D_TOT; opa = tot_reg; opb = bl_reg;  end
            5'd25: begin op = OP_ADD; dst = D_TOT; opa = tot_reg; opb = integ_reg; end
            5'd26: begin op = OP_DIV; dst = D_OUT; opa = tot_reg; opb = c45_reg; end
            5'd27: begin op = OP_MUL; dst = D_P0;  opa = e1_reg;  opb = C_11;    end
            5'd28: begin op = OP_ADD; dst = D_P1;  opa = p0_reg;  opb = de1_reg; end
            5'd29: begin op = OP_DIV; dst = D_P0;  opa = p1_reg;  opb = C_50000; end
            5'd30: begin op = OP_ADD; dst = D_INT; opa = integ_reg; opb = p0_reg; end
            default: begin op = OP_ADD; dst = D_P2; opa = '0; opb = '0; end
        endcase
        if (op == OP_SUB)
            alu_res = sat_sum({opa[W-1], opa} - {opb[W-1], opb});
        else
            alu_res = sat_sum({opa[W-1], opa} + {opb[W-1], opb});
        res = (op == OP_MUL) ? mul_y : (op == OP_DIV) ? div_y : alu_res;
        unit_start = (state_reg == ST_EXEC) && (op == OP_MUL || op == OP_DIV)
                     && !(pc_reg == OUT_STEP && m_tvalid_reg && !m_tready);
        wr_en = ((state_reg == ST_EXEC) && (op == OP_ADD || op == OP_SUB))
                || ((state_reg == ST_WAIT) && (mul_done || div_done));
        v_in = {{(W-22){1'b0}}, s_tdata[211:190]};
        if (v_in < C_ONE)
            v_in = C_ONE;
        else if (v_in > C_V40)
            v_in = C_V40;
    end

    asms_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .clk(clk), .rst_n(rst_n), .start(unit_start && op == OP_MUL),
        .a(opa), .b(opb), .done(mul_done), .y(mul_y)
    );

    asms_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(unit_start && op == OP_DIV),
        .a(opa), .b(opb), .done(div_done), .y(div_y)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg <= '0;
            integ_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (m_tvalid_reg && m_tready)
                m_tvalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        state_reg <= ST_EXEC;
                        pc_reg <= '0;
                    end
                end
                ST_EXEC:
                begin
                    if (unit_start)
                        state_reg <= ST_WAIT;
                    else if (wr_en)
                    begin
                        pc_reg <= pc_reg + 1'b1;
                        if (pc_reg == LAST_STEP)
                            state_reg <= ST_IDLE;
                    end
                end
                ST_WAIT:
                begin
                    if (wr_en)
                    begin
                        pc_reg <= pc_reg + 1'b1;
                        state_reg <= ST_EXEC;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            if (wr_en && dst == D_INT)
                integ_reg <= clamp32(res);
            if (wr_en && dst == D_OUT)
                m_tvalid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_tvalid)
        begin
            vy_reg <= word_t'(signed'(s_tdata[31:0]));
            r_reg <= word_t'(signed'(s_tdata[63:32]));
            e1_reg <= word_t'(signed'(s_tdata[95:64]));
            de1_reg <= word_t'(signed'(s_tdata[127:96]));
            q_reg <= {{(W-31){1'b0}}, s_tdata[158:128]};
            c_reg <= {{(W-31){1'b0}}, s_tdata[189:159]};
            v_reg <= v_in;
        end
        if (wr_en)
        begin
            case (dst)
                D_P0:  p0_reg <= res;
                D_P1:  p1_reg <= res;
                D_P2:  p2_reg <= res;
                D_C41: c41_reg <= res;
                D_C42: c42_reg <= res;
                D_C44: c44_reg <= res;
                D_C45: c45_reg <= res;
                D_H:   h_reg <= res;
                D_S:   s_reg <= res;
                D_BL:  bl_reg <= res;
                D_TQ:  tq_reg <= res;
                D_TOT: tot_reg <= res;
                D_OUT: m_tdata_reg <= 32'(clamp32(res));
                default: ;
            endcase
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;

endmodule
